[src/stereo_pan_mixer_defines.svh]
// ----------------------------------------------------------------------------
// Stereo pan mixer assertion macros
// Shared property shapes for the mixer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef STEREO_PAN_MIXER_DEFINES_SVH
`define STEREO_PAN_MIXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SPM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/spm_pkg.sv]
// ----------------------------------------------------------------------------
// Stereo pan mixer package
// Shared widths, register codes, item types and the sine table generator.
// ----------------------------------------------------------------------------
package spm_pkg;

	localparam int CHAN_SLOTS         = 4;
	localparam int NUM_CHANNELS_DEF   = 4;
	localparam int SINE_DEPTH_DEF     = 256;
	localparam int QUEUE_DEPTH        = 2;

	localparam int SMP_W    = 16;
	localparam int VOL_W    = 17;
	localparam int PAN_W    = 16;
	localparam int SET_W    = 34;
	localparam int CFG_IDX_W = 8;
	localparam int ACC_W    = 52;

	localparam logic [VOL_W-1:0] VOL_MAX    = 17'd65536;
	localparam logic [VOL_W-1:0] VOL_SILENT = 17'd3;
	localparam logic [PAN_W-1:0] PAN_MAX    = 16'd32768;
	localparam logic [13:0]      XTALK_Q15  = 14'd3277;
	localparam logic [SET_W-1:0] SET_RESET  = 34'h2_8000_8000;

	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHAN0 = 8'd0,
		CFG_CHAN1 = 8'd1,
		CFG_CHAN2 = 8'd2,
		CFG_CHAN3 = 8'd3,
		CFG_MODE  = 8'd4
	} cfg_idx_t;

	typedef enum logic {
		MODE_STEREO = 1'b0,
		MODE_MONO   = 1'b1
	} mode_t;

	typedef struct packed {
		logic                     active;
		logic [VOL_W-1:0]         vol;
		logic [PAN_W-1:0]         pan;
		logic signed [SMP_W-1:0]  left;
		logic signed [SMP_W-1:0]  right;
	} lane_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic busy;
		logic mono;
	} back_stat_t;

	// Sine of a Q30 angle in Q15, rounded, from a Horner-form Taylor series.
	function automatic logic [15:0] sine_q15(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		x2 = (x * x) >> 30;
		t = ONE_Q30;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		r = (s + 64'd16384) >> 15;
		if (r > 64'd32768) begin
			r = 64'd32768;
		end
		return r[15:0];
	endfunction

endpackage

[src/spm_front.sv]
// ----------------------------------------------------------------------------
// Stereo pan mixer front end
// Accepts frames, clamps each channel's volume and pan and marks whether it is active.
// ----------------------------------------------------------------------------
module spm_front #(
	parameter int NUM_CHANNELS = spm_pkg::NUM_CHANNELS_DEF,
	parameter int DATA_W       = NUM_CHANNELS * $bits(spm_pkg::lane_t) + 2
) (
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [spm_pkg::SET_W-1:0]         chan_set [spm_pkg::CHAN_SLOTS],
	input  spm_pkg::mode_t                    mode,
	input  logic signed [spm_pkg::SMP_W-1:0]  smp_left [spm_pkg::CHAN_SLOTS],
	input  logic signed [spm_pkg::SMP_W-1:0]  smp_right [spm_pkg::CHAN_SLOTS],
	input  logic                              block_end_in,
	input  spm_pkg::q_stat_t                  q_stat,
	output logic                              push,
	output logic [DATA_W-1:0]                 push_data
);

	spm_pkg::lane_t [NUM_CHANNELS-1:0] lanes;
	logic [spm_pkg::VOL_W-1:0] vol_raw [NUM_CHANNELS];
	logic [spm_pkg::PAN_W-1:0] pan_raw [NUM_CHANNELS];

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			vol_raw[c] = chan_set[c][16:0];
			pan_raw[c] = chan_set[c][32:17];
			lanes[c].vol = (vol_raw[c] > spm_pkg::VOL_MAX) ? spm_pkg::VOL_MAX : vol_raw[c];
			lanes[c].pan = (pan_raw[c] > spm_pkg::PAN_MAX) ? spm_pkg::PAN_MAX : pan_raw[c];
			lanes[c].active = !chan_set[c][33] && (lanes[c].vol > spm_pkg::VOL_SILENT);
			lanes[c].left = smp_left[c];
			lanes[c].right = smp_right[c];
		end
	end

	assign in_ready  = !q_stat.full;
	assign push      = in_valid && in_ready;
	assign push_data = {block_end_in, mode, lanes};

endmodule

[src/spm_queue.sv]
// ----------------------------------------------------------------------------
// Stereo pan mixer item queue
// Short FIFO between the front end and the mixing pipeline.
// ----------------------------------------------------------------------------
module spm_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = spm_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output spm_pkg::q_stat_t  q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data     = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CNT_W'(DEPTH));

endmodule

[src/spm_lane.sv]
// ----------------------------------------------------------------------------
// Stereo pan mixer channel lane
// Five-stage pipeline: gain lookup, gain, products, crosstalk, contribution.
// ----------------------------------------------------------------------------
module spm_lane #(
	parameter int SINE_TABLE_DEPTH = spm_pkg::SINE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  spm_pkg::lane_t                    lane_in,
	input  spm_pkg::mode_t                    mode_in,
	output logic signed [spm_pkg::ACC_W-1:0]  acc_left,
	output logic signed [spm_pkg::ACC_W-1:0]  acc_right
);

	localparam int TBL_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int POS_W = spm_pkg::PAN_W + TBL_W;
	localparam int ACC_W = spm_pkg::ACC_W;
	localparam int SIN   = 0;
	localparam int COS   = 1;

	logic [15:0] qsine [SINE_TABLE_DEPTH + 1];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tbl
		localparam logic [63:0] ARG = (64'(k) * spm_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
		assign qsine[k] = spm_pkg::sine_q15(ARG);
	end

	logic [spm_pkg::PAN_W-1:0] pan_sel [2];
	logic [POS_W-1:0]          pos [2];
	logic [TBL_W-1:0]          idx [2];
	logic [TBL_W-1:0]          nxt [2];
	logic [14:0]               frac [2];
	logic signed [16:0]        diff [2];
	logic signed [32:0]        dprod [2];

	always_comb begin
		pan_sel[SIN] = lane_in.pan;
		pan_sel[COS] = spm_pkg::PAN_MAX - lane_in.pan;
		for (int j = 0; j < 2; j++) begin
			pos[j]   = POS_W'(pan_sel[j]) * POS_W'(SINE_TABLE_DEPTH);
			idx[j]   = pos[j][15 +: TBL_W];
			nxt[j]   = (idx[j] == TBL_W'(SINE_TABLE_DEPTH)) ? idx[j] : idx[j] + 1'b1;
			frac[j]  = pos[j][14:0];
			diff[j]  = $signed({1'b0, qsine[nxt[j]]}) - $signed({1'b0, qsine[idx[j]]});
			dprod[j] = diff[j] * $signed({1'b0, frac[j]});
		end
	end

	// Stage 1: table interpolation products.
	logic [15:0]                      a_s1 [2];
	logic signed [32:0]               d_s1 [2];
	logic [spm_pkg::VOL_W-1:0]        vol_s1;
	logic signed [spm_pkg::SMP_W-1:0] left_s1;
	logic signed [spm_pkg::SMP_W-1:0] right_s1;
	logic signed [16:0]               lr_s1;
	logic                             act_s1;
	spm_pkg::mode_t                   mode_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 2; j++) begin
				a_s1[j] <= qsine[idx[j]];
				d_s1[j] <= dprod[j];
			end
			vol_s1   <= lane_in.vol;
			left_s1  <= lane_in.left;
			right_s1 <= lane_in.right;
			lr_s1    <= 17'(lane_in.left) + 17'(lane_in.right);
			act_s1   <= lane_in.active;
			mode_s1  <= mode_in;
		end
	end

	// Stage 2: trig value times volume, and the mono product.
	logic signed [17:0] trig [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			trig[j] = $signed({2'b00, a_s1[j]}) + 18'(d_s1[j] >>> 15);
		end
	end

	logic [32:0]                      gp_s2 [2];
	logic signed [34:0]               mp_s2;
	logic signed [spm_pkg::SMP_W-1:0] left_s2;
	logic signed [spm_pkg::SMP_W-1:0] right_s2;
	logic                             act_s2;
	spm_pkg::mode_t                   mode_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 2; j++) begin
				gp_s2[j] <= 33'(trig[j][15:0]) * 33'(vol_s1);
			end
			mp_s2    <= lr_s1 * $signed({1'b0, vol_s1});
			left_s2  <= left_s1;
			right_s2 <= right_s1;
			act_s2   <= act_s1;
			mode_s2  <= mode_s1;
		end
	end

	// Stage 3: rounded gains applied to the samples.
	logic [16:0] gain [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			gain[j] = 17'((gp_s2[j] + 33'd16384) >> 15);
		end
	end

	logic signed [33:0] tl_s3;
	logic signed [33:0] tr_s3;
	logic signed [34:0] mp_s3;
	logic               act_s3;
	spm_pkg::mode_t     mode_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			tl_s3   <= left_s2 * $signed({1'b0, gain[COS]});
			tr_s3   <= right_s2 * $signed({1'b0, gain[SIN]});
			mp_s3   <= mp_s2;
			act_s3  <= act_s2;
			mode_s3 <= mode_s2;
		end
	end

	// Stage 4: crosstalk terms.
	logic signed [33:0] tl_s4;
	logic signed [33:0] tr_s4;
	logic signed [47:0] tlx_s4;
	logic signed [47:0] trx_s4;
	logic signed [34:0] mp_s4;
	logic               act_s4;
	spm_pkg::mode_t     mode_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			tl_s4   <= tl_s3;
			tr_s4   <= tr_s3;
			tlx_s4  <= tl_s3 * $signed(spm_pkg::XTALK_Q15);
			trx_s4  <= tr_s3 * $signed(spm_pkg::XTALK_Q15);
			mp_s4   <= mp_s3;
			act_s4  <= act_s3;
			mode_s4 <= mode_s3;
		end
	end

	// Stage 5: per-channel contribution in Q45.
	logic signed [ACC_W-1:0] acc_l_s5;
	logic signed [ACC_W-1:0] acc_r_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!act_s4) begin
				acc_l_s5 <= '0;
				acc_r_s5 <= '0;
			end else if (mode_s4 == spm_pkg::MODE_MONO) begin
				acc_l_s5 <= ACC_W'(mp_s4) <<< 14;
				acc_r_s5 <= ACC_W'(mp_s4) <<< 14;
			end else begin
				acc_l_s5 <= (ACC_W'(tl_s4) <<< 15) + ACC_W'(trx_s4);
				acc_r_s5 <= (ACC_W'(tr_s4) <<< 15) + ACC_W'(tlx_s4);
			end
		end
	end

	assign acc_left  = acc_l_s5;
	assign acc_right = acc_r_s5;

endmodule

[src/spm_back.sv]
// ----------------------------------------------------------------------------
// Stereo pan mixer back end
// Channel lanes, summing tree, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module spm_back #(
	parameter int NUM_CHANNELS     = spm_pkg::NUM_CHANNELS_DEF,
	parameter int SINE_TABLE_DEPTH = spm_pkg::SINE_DEPTH_DEF,
	parameter int DATA_W           = NUM_CHANNELS * $bits(spm_pkg::lane_t) + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spm_pkg::q_stat_t                  q_stat,
	input  logic [DATA_W-1:0]                 pop_data,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [spm_pkg::SMP_W-1:0]  out_left,
	output logic signed [spm_pkg::SMP_W-1:0]  out_right,
	output logic                              clipped,
	output logic                              block_end_out,
	output spm_pkg::back_stat_t               back_stat
);

	localparam int ACC_W = spm_pkg::ACC_W;
	localparam int RND_W = ACC_W - 30;

	spm_pkg::lane_t [NUM_CHANNELS-1:0] lanes;
	spm_pkg::mode_t                    mode_in;
	logic                              mode_bit;
	logic                              be_in;
	logic                              en;

	assign {be_in, mode_bit, lanes} = pop_data;
	assign mode_in = spm_pkg::mode_t'(mode_bit);

	logic              out_valid_q;
	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_stat.empty;

	logic signed [ACC_W-1:0] contrib_l [spm_pkg::CHAN_SLOTS];
	logic signed [ACC_W-1:0] contrib_r [spm_pkg::CHAN_SLOTS];

	for (genvar c = 0; c < spm_pkg::CHAN_SLOTS; c++) begin : g_lane
		if (c < NUM_CHANNELS) begin : g_on
			spm_lane #(
				.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
			) u_lane (
				.clk      (clk),
				.en       (en),
				.lane_in  (lanes[c]),
				.mode_in  (mode_in),
				.acc_left (contrib_l[c]),
				.acc_right(contrib_r[c])
			);
		end else begin : g_off
			assign contrib_l[c] = '0;
			assign contrib_r[c] = '0;
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic be_s1, be_s2, be_s3, be_s4, be_s5, be_s6;
	spm_pkg::mode_t md_s1, md_s2, md_s3, md_s4, md_s5, md_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_stat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			be_s1 <= be_in;
			be_s2 <= be_s1;
			be_s3 <= be_s2;
			be_s4 <= be_s3;
			be_s5 <= be_s4;
			be_s6 <= be_s5;
			md_s1 <= mode_in;
			md_s2 <= md_s1;
			md_s3 <= md_s2;
			md_s4 <= md_s3;
			md_s5 <= md_s4;
			md_s6 <= md_s5;
		end
	end

	// Stage 6: pairwise channel sums.
	logic signed [ACC_W-1:0] sum_l_s6 [2];
	logic signed [ACC_W-1:0] sum_r_s6 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 2; p++) begin
				sum_l_s6[p] <= contrib_l[2 * p] + contrib_l[2 * p + 1];
				sum_r_s6[p] <= contrib_r[2 * p] + contrib_r[2 * p + 1];
			end
		end
	end

	// Output stage: total, round half up to Q15, saturate.
	logic signed [ACC_W-1:0] tot [2];
	logic signed [RND_W-1:0] rnd [2];
	logic signed [spm_pkg::SMP_W-1:0] sat [2];
	logic [1:0] clip;

	always_comb begin
		for (int s = 0; s < 2; s++) begin
			tot[s] = (s == 0) ? sum_l_s6[0] + sum_l_s6[1] : sum_r_s6[0] + sum_r_s6[1];
			rnd[s] = RND_W'((tot[s] + ACC_W'(64'sd536870912)) >>> 30);
			if (rnd[s] > RND_W'(32767)) begin
				sat[s]  = 16'sd32767;
				clip[s] = 1'b1;
			end else if (rnd[s] < -RND_W'(32768)) begin
				sat[s]  = -16'sd32768;
				clip[s] = 1'b1;
			end else begin
				sat[s]  = rnd[s][spm_pkg::SMP_W-1:0];
				clip[s] = 1'b0;
			end
		end
	end

	logic signed [spm_pkg::SMP_W-1:0] out_left_q;
	logic signed [spm_pkg::SMP_W-1:0] out_right_q;
	logic                             clipped_q;
	logic                             be_q;
	logic                             mono_q;

	always_ff @(posedge clk) begin
		if (en) begin
			out_left_q  <= sat[0];
			out_right_q <= sat[1];
			clipped_q   <= |clip;
			be_q        <= be_s6;
			mono_q      <= (md_s6 == spm_pkg::MODE_MONO);
		end
	end

	assign out_valid      = out_valid_q;
	assign out_left       = out_left_q;
	assign out_right      = out_right_q;
	assign clipped        = clipped_q;
	assign block_end_out  = be_q;
	assign back_stat.mono = mono_q;
	assign back_stat.busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6 || out_valid_q;

endmodule

[src/stereo_pan_mixer.sv]
// ----------------------------------------------------------------------------
// Stereo pan mixer
// Four-channel constant-power pan mixer with stereo and mono output modes.
// ----------------------------------------------------------------------------
// The input channel takes one frame per item: a Q1.15 left and right sample
// for each channel and a block end mark. The output channel gives one mixed,
// saturated stereo frame per item with a clip flag and the copied mark.
// Both channels use valid and ready; the configuration channel writes the
// four channel settings and the output mode and is always ready. Write it
// only while no frame is in flight.
// Throughput is one frame per cycle while the receiver keeps ready high. An
// accepted frame passes through the two-entry queue, five stages in each
// channel lane and one summing stage before the output register.
// When the receiver holds ready low on a valid frame, the pipeline freezes
// while the queue keeps taking frames until its two entries are full; then
// in_ready drops. Reset empties the queue and pipeline, loads the default
// settings: unity volume, center pan, every channel bypassed, stereo mode.
// ----------------------------------------------------------------------------
`include "stereo_pan_mixer_defines.svh"

module stereo_pan_mixer #(
	parameter int NUM_CHANNELS     = spm_pkg::NUM_CHANNELS_DEF,
	parameter int SINE_TABLE_DEPTH = spm_pkg::SINE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [spm_pkg::SMP_W-1:0]      ch0_left,
	input  logic signed [spm_pkg::SMP_W-1:0]      ch0_right,
	input  logic signed [spm_pkg::SMP_W-1:0]      ch1_left,
	input  logic signed [spm_pkg::SMP_W-1:0]      ch1_right,
	input  logic signed [spm_pkg::SMP_W-1:0]      ch2_left,
	input  logic signed [spm_pkg::SMP_W-1:0]      ch2_right,
	input  logic signed [spm_pkg::SMP_W-1:0]      ch3_left,
	input  logic signed [spm_pkg::SMP_W-1:0]      ch3_right,
	input  logic                                  block_end_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [spm_pkg::SMP_W-1:0]      out_left,
	output logic signed [spm_pkg::SMP_W-1:0]      out_right,
	output logic                                  clipped,
	output logic                                  block_end_out,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [spm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [spm_pkg::SET_W-1:0]             cfg_data
);

	localparam int DATA_W = NUM_CHANNELS * $bits(spm_pkg::lane_t) + 2;

	logic [spm_pkg::SET_W-1:0] chan_set_q [spm_pkg::CHAN_SLOTS];
	spm_pkg::mode_t            mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < spm_pkg::CHAN_SLOTS; c++) begin
				chan_set_q[c] <= spm_pkg::SET_RESET;
			end
			mode_q <= spm_pkg::MODE_STEREO;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				spm_pkg::CFG_CHAN0: chan_set_q[0] <= cfg_data;
				spm_pkg::CFG_CHAN1: chan_set_q[1] <= cfg_data;
				spm_pkg::CFG_CHAN2: chan_set_q[2] <= cfg_data;
				spm_pkg::CFG_CHAN3: chan_set_q[3] <= cfg_data;
				spm_pkg::CFG_MODE:  mode_q <= spm_pkg::mode_t'(cfg_data[0]);
				default: begin
				end
			endcase
		end
	end

	logic signed [spm_pkg::SMP_W-1:0] smp_left [spm_pkg::CHAN_SLOTS];
	logic signed [spm_pkg::SMP_W-1:0] smp_right [spm_pkg::CHAN_SLOTS];

	assign smp_left[0]  = ch0_left;
	assign smp_right[0] = ch0_right;
	assign smp_left[1]  = ch1_left;
	assign smp_right[1] = ch1_right;
	assign smp_left[2]  = ch2_left;
	assign smp_right[2] = ch2_right;
	assign smp_left[3]  = ch3_left;
	assign smp_right[3] = ch3_right;

	spm_pkg::q_stat_t    q_stat;
	spm_pkg::back_stat_t back_stat;
	logic                push;
	logic                pop;
	logic [DATA_W-1:0]   push_data;
	logic [DATA_W-1:0]   pop_data;

	spm_front #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.DATA_W      (DATA_W)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.chan_set    (chan_set_q),
		.mode        (mode_q),
		.smp_left    (smp_left),
		.smp_right   (smp_right),
		.block_end_in(block_end_in),
		.q_stat      (q_stat),
		.push        (push),
		.push_data   (push_data)
	);

	spm_queue #(
		.DATA_W(DATA_W),
		.DEPTH (spm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.q_stat   (q_stat)
	);

	spm_back #(
		.NUM_CHANNELS    (NUM_CHANNELS),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.DATA_W          (DATA_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_left     (out_left),
		.out_right    (out_right),
		.clipped      (clipped),
		.block_end_out(block_end_out),
		.back_stat    (back_stat)
	);

	`SPM_ASSERT_NXT(a_push_fills, push, !q_stat.empty, "queue empty after a push")
	`SPM_ASSERT_IMP(a_q_flags, 1'b1, !(q_stat.empty && q_stat.full), "queue empty and full")
	`SPM_ASSERT_IMP(a_mono_same, out_valid && back_stat.mono, out_left == out_right,
		"mono frame with differing outputs")
	`SPM_ASSERT_IMP(a_idle_quiet, !back_stat.busy, !out_valid, "output valid while idle")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Stereo pan mixer testbench
// Drives frames through the mixer under random idling and back-pressure and
// checks every output item against a bit-exact fixed-point mix predictor.
// ----------------------------------------------------------------------------
// Directed tests cover the reset settings, hard and center pan, volumes
// above range, near-silent and bypassed channels, mono downmix, masked mode
// writes, unused register indexes and saturation. Random phases then change
// all registers between bursts of frames. The receiver holds off once for a
// long stretch so that the mixer fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SMP_W = spm_pkg::SMP_W;
	localparam int SET_W = spm_pkg::SET_W;
	localparam int VOL_W = spm_pkg::VOL_W;
	localparam int PAN_W = spm_pkg::PAN_W;
	localparam int CFG_IDX_W = spm_pkg::CFG_IDX_W;
	localparam int LANES = 4;
	localparam int TABLE_DEPTH = 256;
	localparam int LATENCY = 7;
	localparam int RANDOM_PHASES = 8;
	localparam int FRAMES_PER_PHASE = 150;
	localparam int IDLE_LIMIT = 20000;
	localparam int REPORT_LIMIT = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 8'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 8'd255;
	localparam longint VOL_TOP = spm_pkg::VOL_MAX;
	localparam longint VOL_FLOOR = spm_pkg::VOL_SILENT;
	localparam longint PAN_TOP = spm_pkg::PAN_MAX;
	localparam longint XTALK = spm_pkg::XTALK_Q15;
	localparam longint UNITY_Q15 = 32768;
	localparam longint HALF_Q15 = 16384;
	localparam longint HALF_Q30 = 536870912;
	localparam longint SAT_HI = 32767;
	localparam longint SAT_LO = -32768;

	typedef struct packed {
		logic [LANES-1:0][SMP_W-1:0] left;
		logic [LANES-1:0][SMP_W-1:0] right;
		logic                        block_end;
	} frame_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
		logic                    clip;
		logic                    block_end;
	} mix_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] idx;
		logic [SET_W-1:0]     data;
	} reg_write_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [SMP_W-1:0] ch0_left = '0;
	logic signed [SMP_W-1:0] ch0_right = '0;
	logic signed [SMP_W-1:0] ch1_left = '0;
	logic signed [SMP_W-1:0] ch1_right = '0;
	logic signed [SMP_W-1:0] ch2_left = '0;
	logic signed [SMP_W-1:0] ch2_right = '0;
	logic signed [SMP_W-1:0] ch3_left = '0;
	logic signed [SMP_W-1:0] ch3_right = '0;
	logic                    block_end_in = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [SMP_W-1:0] out_left;
	logic signed [SMP_W-1:0] out_right;
	logic                    clipped;
	logic                    block_end_out;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [SET_W-1:0]        cfg_data = '0;

	logic [15:0]      sine_tab [0:TABLE_DEPTH];
	logic [SET_W-1:0] chan_cfg [LANES];
	spm_pkg::mode_t   mix_mode;
	mix_out_t         pending_mix [$];

	int  mismatches = 0;
	int  drain_timeouts = 0;
	int  frames_sent = 0;
	int  mixes_checked = 0;
	int  clip_count = 0;
	int  block_end_count = 0;
	int  reg_writes = 0;
	int  input_stall_cycles = 0;
	int  hold_len = 0;
	bit  no_idle = 1'b0;
	bit  rx_holding = 1'b0;

	stereo_pan_mixer uut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("stereo_pan_mixer test failed");
		$finish;
	end

	function automatic logic [15:0] sine_entry(input bit [63:0] ang);
		bit [63:0]   sq;
		bit [63:0]   series;
		bit [63:0]   prod;
		bit [63:0]   rnd;
		int unsigned divs [6];
		int          i;
		divs = '{156, 110, 72, 42, 20, 6};
		sq = (ang * ang) >> 30;
		series = spm_pkg::ONE_Q30;
		for (i = 0; i < 6; i++) begin
			series = spm_pkg::ONE_Q30 - ((sq * series) >> 30) / divs[i];
		end
		prod = (ang * series) >> 30;
		rnd = (prod + 64'd16384) >> 15;
		if (rnd > 64'd32768) begin
			rnd = 64'd32768;
		end
		return rnd[15:0];
	endfunction

	function automatic longint table_interp(input longint p);
		longint pos;
		longint idx;
		longint frac;
		longint lo;
		longint hi;
		pos = p * TABLE_DEPTH;
		idx = pos >>> 15;
		frac = pos & 'h7FFF;
		if (idx >= TABLE_DEPTH) begin
			return longint'(sine_tab[TABLE_DEPTH]);
		end
		lo = longint'(sine_tab[idx]);
		hi = longint'(sine_tab[idx + 1]);
		return lo + (((hi - lo) * frac) >>> 15);
	endfunction

	function automatic mix_out_t mix_frame(input frame_t f);
		mix_out_t res;
		longint   acc_l;
		longint   acc_r;
		longint   vol;
		longint   pan;
		longint   smp_l;
		longint   smp_r;
		longint   g_l;
		longint   g_r;
		longint   t_l;
		longint   t_r;
		longint   mono;
		int       c;
		acc_l = 0;
		acc_r = 0;
		for (c = 0; c < LANES; c++) begin
			if (chan_cfg[c][SET_W-1]) begin
				continue;
			end
			vol = longint'(chan_cfg[c][16:0]);
			pan = longint'(chan_cfg[c][32:17]);
			if (vol > VOL_TOP) begin
				vol = VOL_TOP;
			end
			if (pan > PAN_TOP) begin
				pan = PAN_TOP;
			end
			if (vol <= VOL_FLOOR) begin
				continue;
			end
			smp_l = $signed(f.left[c]);
			smp_r = $signed(f.right[c]);
			if (mix_mode == spm_pkg::MODE_STEREO) begin
				g_l = (table_interp(PAN_TOP - pan) * vol + HALF_Q15) >>> 15;
				g_r = (table_interp(pan) * vol + HALF_Q15) >>> 15;
				t_l = smp_l * g_l;
				t_r = smp_r * g_r;
				acc_l += t_l * UNITY_Q15 + t_r * XTALK;
				acc_r += t_r * UNITY_Q15 + t_l * XTALK;
			end else begin
				mono = (smp_l + smp_r) * vol * HALF_Q15;
				acc_l += mono;
				acc_r += mono;
			end
		end
		acc_l = (acc_l + HALF_Q30) >>> 30;
		acc_r = (acc_r + HALF_Q30) >>> 30;
		res.clip = 1'b0;
		if (acc_l > SAT_HI) begin
			acc_l = SAT_HI;
			res.clip = 1'b1;
		end else if (acc_l < SAT_LO) begin
			acc_l = SAT_LO;
			res.clip = 1'b1;
		end
		if (acc_r > SAT_HI) begin
			acc_r = SAT_HI;
			res.clip = 1'b1;
		end else if (acc_r < SAT_LO) begin
			acc_r = SAT_LO;
			res.clip = 1'b1;
		end
		res.left = acc_l[15:0];
		res.right = acc_r[15:0];
		res.block_end = f.block_end;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [SET_W-1:0] pack_setting(input logic bypass,
			input logic [PAN_W-1:0] pan, input logic [VOL_W-1:0] vol);
		return {bypass, pan, vol};
	endfunction

	function automatic logic [SET_W-1:0] random_setting();
		logic [VOL_W-1:0] vol;
		logic [PAN_W-1:0] pan;
		case ($urandom_range(0, 9))
			0: begin
				vol = VOL_W'($urandom_range(0, 3));
			end
			1: begin
				vol = VOL_W'($urandom_range(65536, 131071));
			end
			default: begin
				vol = VOL_W'($urandom_range(4, 65536));
			end
		endcase
		if ($urandom_range(0, 7) == 0) begin
			pan = PAN_W'($urandom_range(32769, 65535));
		end else begin
			pan = PAN_W'($urandom_range(0, 32768));
		end
		return pack_setting($urandom_range(0, 4) == 0, pan, vol);
	endfunction

	function automatic logic [SMP_W-1:0] random_sample();
		case ($urandom_range(0, 19))
			0: begin
				return 16'h7FFF;
			end
			1: begin
				return 16'h8000;
			end
			default: begin
				return SMP_W'($urandom());
			end
		endcase
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int     c;
		for (c = 0; c < LANES; c++) begin
			f.left[c] = random_sample();
			f.right[c] = random_sample();
		end
		f.block_end = ($urandom_range(0, 7) == 0);
		return f;
	endfunction

	function automatic frame_t flat_frame(input logic [SMP_W-1:0] l,
			input logic [SMP_W-1:0] r, input logic blk);
		frame_t f;
		int     c;
		for (c = 0; c < LANES; c++) begin
			f.left[c] = l;
			f.right[c] = r;
		end
		f.block_end = blk;
		return f;
	endfunction

	task automatic send_frame(input frame_t f);
		int gap;
		in_valid <= 1'b1;
		ch0_left <= f.left[0];
		ch0_right <= f.right[0];
		ch1_left <= f.left[1];
		ch1_right <= f.right[1];
		ch2_left <= f.left[2];
		ch2_right <= f.right[2];
		ch3_left <= f.left[3];
		ch3_right <= f.right[3];
		block_end_in <= f.block_end;
		do begin
			@(posedge clk);
		end while (!in_ready);
		pending_mix.insert(pending_mix.size(), mix_frame(f));
		frames_sent++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (pending_mix.size() != 0 && waited < IDLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_mix.size() != 0) begin
			drain_timeouts++;
			$display("%0t: %0d mixed items never arrived", $realtime, pending_mix.size());
		end
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_regs(input reg_write_t writes [$]);
		int i;
		wait_idle();
		for (i = 0; i < writes.size(); i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= writes[i].idx;
			cfg_data <= writes[i].data;
			do begin
				@(posedge clk);
			end while (!cfg_ready);
			if (writes[i].idx < LANES) begin
				chan_cfg[writes[i].idx] = writes[i].data;
			end else if (writes[i].idx == spm_pkg::CFG_MODE) begin
				mix_mode = spm_pkg::mode_t'(writes[i].data[0]);
			end
			reg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mix(input logic [SET_W-1:0] s0, input logic [SET_W-1:0] s1,
			input logic [SET_W-1:0] s2, input logic [SET_W-1:0] s3,
			input spm_pkg::mode_t mode);
		reg_write_t writes [$];
		writes.insert(writes.size(), reg_write_t'{spm_pkg::CFG_CHAN0, s0});
		writes.insert(writes.size(), reg_write_t'{spm_pkg::CFG_CHAN1, s1});
		writes.insert(writes.size(), reg_write_t'{spm_pkg::CFG_CHAN2, s2});
		writes.insert(writes.size(), reg_write_t'{spm_pkg::CFG_CHAN3, s3});
		writes.insert(writes.size(),
			reg_write_t'{spm_pkg::CFG_MODE, {{(SET_W-1){1'b0}}, mode}});
		write_regs(writes);
	endtask

	task automatic test_defaults();
		send_frame(flat_frame(16'h7FFF, 16'h7FFF, 1'b1));
		send_frame(flat_frame(16'h8000, 16'h8000, 1'b0));
		send_frame(random_frame());
	endtask

	task automatic test_stereo_pan();
		frame_t solo;
		set_mix(pack_setting(1'b0, 16'd0, 17'd32768),
			pack_setting(1'b0, spm_pkg::PAN_MAX, 17'd32768),
			pack_setting(1'b0, 16'd16384, spm_pkg::VOL_MAX),
			pack_setting(1'b0, 16'hFFFF, 17'h1FFFF), spm_pkg::MODE_STEREO);
		send_frame(flat_frame(16'h7FFF, 16'h7FFF, 1'b0));
		send_frame(flat_frame(16'h8000, 16'h8000, 1'b1));
		send_frame(flat_frame(16'h7FFF, 16'h8000, 1'b0));
		send_frame(flat_frame(16'h0000, 16'h0000, 1'b1));
		solo = flat_frame(16'h0000, 16'h0000, 1'b0);
		solo.left[0] = 16'h7FFF;
		send_frame(solo);
		solo = flat_frame(16'h0000, 16'h0000, 1'b0);
		solo.right[1] = 16'h8000;
		send_frame(solo);
	endtask

	task automatic test_quiet_and_bypass();
		set_mix(pack_setting(1'b0, 16'd16384, 17'd3),
			pack_setting(1'b0, 16'd8000, 17'd4),
			pack_setting(1'b1, 16'd16384, spm_pkg::VOL_MAX),
			pack_setting(1'b0, 16'd32769, 17'd0), spm_pkg::MODE_STEREO);
		send_frame(flat_frame(16'h7FFF, 16'h7FFF, 1'b0));
		send_frame(flat_frame(16'h8000, 16'h7FFF, 1'b1));
		send_frame(random_frame());
	endtask

	task automatic test_mono();
		reg_write_t writes [$];
		set_mix(pack_setting(1'b0, 16'd0, spm_pkg::VOL_MAX),
			pack_setting(1'b0, spm_pkg::PAN_MAX, 17'd16384),
			pack_setting(1'b0, 16'd16384, 17'h1FFFF),
			pack_setting(1'b1, 16'd0, spm_pkg::VOL_MAX), spm_pkg::MODE_STEREO);
		writes.insert(writes.size(), reg_write_t'{spm_pkg::CFG_MODE, {SET_W{1'b1}}});
		write_regs(writes);
		send_frame(flat_frame(16'h7FFF, 16'h7FFF, 1'b1));
		send_frame(flat_frame(16'h8000, 16'h8000, 1'b0));
		send_frame(flat_frame(16'h7FFF, 16'h8000, 1'b0));
		send_frame(flat_frame(16'h1000, 16'h0FFF, 1'b1));
		writes.delete();
		writes.insert(writes.size(),
			reg_write_t'{spm_pkg::CFG_MODE, {{(SET_W-1){1'b1}}, spm_pkg::MODE_STEREO}});
		write_regs(writes);
		send_frame(random_frame());
	endtask

	task automatic test_spare_index();
		reg_write_t writes [$];
		writes.insert(writes.size(), reg_write_t'{CFG_SPARE_LO, {SET_W{1'b1}}});
		writes.insert(writes.size(), reg_write_t'{CFG_SPARE_HI, {SET_W{1'b1}}});
		writes.insert(writes.size(), reg_write_t'{CFG_SPARE_HI, {SET_W{1'b0}}});
		write_regs(writes);
		send_frame(flat_frame(16'h7FFF, 16'h8000, 1'b1));
		send_frame(random_frame());
	endtask

	task automatic test_backpressure();
		int n;
		set_mix(random_setting(), random_setting(), random_setting(), random_setting(),
			spm_pkg::MODE_STEREO);
		no_idle = 1'b1;
		hold_len = 150;
		while (!rx_holding) begin
			@(posedge clk);
		end
		for (n = 0; n < 30; n++) begin
			send_frame(random_frame());
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random_mix();
		logic [SET_W-1:0] s [LANES];
		spm_pkg::mode_t   mode;
		int               ph;
		int               n;
		int               c;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (c = 0; c < LANES; c++) begin
				s[c] = random_setting();
			end
			mode = spm_pkg::mode_t'($urandom_range(0, 1));
			if (ph < 2) begin
				s[0] = pack_setting(1'b0, 16'd0, 17'h1FFFF);
				s[1] = pack_setting(1'b0, 16'hFFFF, 17'h1FFFF);
				s[2] = pack_setting(1'b0, spm_pkg::PAN_MAX, spm_pkg::VOL_MAX);
				s[3] = pack_setting(1'b0, 16'd16384, spm_pkg::VOL_MAX);
				mode = (ph == 0) ? spm_pkg::MODE_STEREO : spm_pkg::MODE_MONO;
			end
			set_mix(s[0], s[1], s[2], s[3], mode);
			no_idle = (ph == 3);
			for (n = 0; n < FRAMES_PER_PHASE; n++) begin
				send_frame(random_frame());
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin : receiver
		int stall;
		forever begin
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				rx_holding = 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				rx_holding = 1'b0;
			end else begin
				stall = no_idle ? 0 : pick_gap();
				out_ready <= (stall == 0);
				repeat ((stall > 0) ? stall : 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_mix
		mix_out_t want;
		if (arst_n) begin
			if (in_valid && !in_ready) begin
				input_stall_cycles++;
			end
			if (out_valid && out_ready) begin
				if (pending_mix.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t: unexpected mixed item L=%0d R=%0d clip=%0b end=%0b",
							$realtime, out_left, out_right, clipped, block_end_out);
					end
				end else begin
					want = pending_mix.pop_front();
					mixes_checked++;
					if (want.clip) begin
						clip_count++;
					end
					if (want.block_end) begin
						block_end_count++;
					end
					if (out_left !== want.left || out_right !== want.right
							|| clipped !== want.clip || block_end_out !== want.block_end) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: mix mismatch, got L=%0d R=%0d clip=%0b end=%0b,",
								$realtime, out_left, out_right, clipped, block_end_out);
							$display("    expected L=%0d R=%0d clip=%0b end=%0b",
								want.left, want.right, want.clip, want.block_end);
						end
					end
				end
			end
		end
	end

	initial begin : run
		int k;
		for (k = 0; k <= TABLE_DEPTH; k++) begin
			sine_tab[k] = sine_entry((64'(k) * spm_pkg::HALF_PI_Q30) / TABLE_DEPTH);
		end
		for (k = 0; k < LANES; k++) begin
			chan_cfg[k] = spm_pkg::SET_RESET;
		end
		mix_mode = spm_pkg::MODE_STEREO;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_stereo_pan();
		test_quiet_and_bypass();
		test_mono();
		test_spare_index();
		test_backpressure();
		test_random_mix();
		wait_idle();
		$display("Checked %0d of %0d frames, %0d clipped and %0d block ends, %0d register writes.",
			mixes_checked, frames_sent, clip_count, block_end_count, reg_writes);
		$display("Input stalled %0d cycles under back-pressure; %0d mismatches.",
			input_stall_cycles, mismatches);
		if (mismatches == 0 && drain_timeouts == 0 && pending_mix.size() == 0) begin
			$display("stereo_pan_mixer test passed");
		end else begin
			$display("stereo_pan_mixer test failed");
		end
		$finish;
	end

endmodule
